[hdl/wtfm_pkg.sv]
package wtfm_pkg;

  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QTR_DEPTH = 256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd4;

  localparam logic [STEP_W-1:0] CARRIER_STEP_RST = 31'd89478485;
  localparam logic [STEP_W-1:0] MOD_STEP_RST     = 31'd447392;
  localparam logic [1:0]        CHAN_COUNT_RST   = 2'd2;

  typedef logic signed [15:0] sample_t;
  typedef logic [15:0] sine_qtr_t [QTR_DEPTH];

  localparam logic signed [15:0] SINE_PEAK = 16'sd32767;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156, 64'd210};

  // q1.15 sine of entry j of the first quadrant, taylor series in q30
  function automatic logic [15:0] sine_q15_qtr(input int unsigned j);
    longint unsigned x;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    longint          v;
    int              k;
    x    = longint'(j) << 22;
    a    = (x * PI_HALF_Q30) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    for (k = 1; k <= 7; k++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[k-1];
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) v = 64'sd32767;
    return v[15:0];
  endfunction

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t t;
    for (int i = 0; i < QTR_DEPTH; i++) begin
      t[i] = sine_q15_qtr(i);
    end
    return t;
  endfunction

  localparam sine_qtr_t SINE_QTR = build_sine_qtr();

  // full-cycle table entry from the quarter table by symmetry
  function automatic sample_t sine_lookup(input logic [IDX_W-1:0] idx);
    logic [1:0] quad;
    logic [8:0] mj;
    sample_t    mag;
    quad = idx[IDX_W-1:IDX_W-2];
    mj   = quad[0] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
    mag  = mj[8] ? SINE_PEAK : sample_t'(SINE_QTR[mj[7:0]]);
    return quad[1] ? -mag : mag;
  endfunction

endpackage

[hdl/wtfm_mul.sv]
module wtfm_mul import wtfm_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [31:0] a_i,
  input  logic signed [16:0] b_i,
  output logic signed [33:0] r15_o,
  output logic signed [32:0] r16_o
);

  logic signed [48:0] prod_q;
  logic signed [48:0] sum15;
  logic signed [48:0] sum16;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= 49'(a_i) * 49'(b_i);
    end
  end

  // round half up, then arithmetic shift
  assign sum15 = prod_q + 49'sd16384;
  assign sum16 = prod_q + 49'sd32768;
  assign r15_o = sum15[48:15];
  assign r16_o = sum16[48:16];

endmodule

[hdl/warble_tone_fm_modulator.sv]
// Warble-tone modulator. Each stereo Q1.15 frame is multiplied by a carrier sine whose
// frequency is swept by a slower modulating sine; both oscillators read one quarter-wave
// sine table with linear interpolation, products are rounded and saturated to Q1.15.
// A frame is taken when in_valid_i is high and in_stall_o is low, and a new frame is
// taken only once the last one is through. With enable set the sequencer walks ten steps
// through one shared 32x17 multiplier (two interpolations, the deviation product and
// the two channel products), and the result is registered at the output. With enable
// clear a frame gives silence and the phases hold. If a result is still stalled at the
// output, the last step waits until the output register is free. Registers are written
// through cfg_we_i/cfg_index_i/cfg_data_i while idle, which the user and not the block
// ensures: 0 carrier step, 1 modulator step, 2 deviation step, 3 channel count, 4 enable.
module warble_tone_fm_modulator import wtfm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   sample_left_i,
  input  logic signed [15:0]   sample_right_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   out_left_o,
  output logic signed [15:0]   out_right_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [STEP_W-1:0]    cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MA   = 4'd1;
  localparam logic [3:0] ST_MB   = 4'd2;
  localparam logic [3:0] ST_CA   = 4'd3;
  localparam logic [3:0] ST_CB   = 4'd4;
  localparam logic [3:0] ST_DV   = 4'd5;
  localparam logic [3:0] ST_CW   = 4'd6;
  localparam logic [3:0] ST_WW   = 4'd7;
  localparam logic [3:0] ST_ML   = 4'd8;
  localparam logic [3:0] ST_MR   = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0]          state_q, state_d;
  logic [STEP_W-1:0]   carrier_step_q;
  logic [STEP_W-1:0]   mod_step_q;
  logic [STEP_W-1:0]   dev_step_q;
  logic [1:0]          chan_count_q;
  logic                enable_q;
  logic [PHASE_W-1:0]  mod_phase_q;
  logic [PHASE_W-1:0]  car_phase_q;
  logic                silent_q;
  logic                out_valid_q;

  sample_t             left_q, right_q;
  sample_t             ms0_q, cs0_q;
  logic signed [16:0]  d_q;
  sample_t             m_q, w_q;
  sample_t             ol_q;
  sample_t             out_left_q, out_right_q;

  logic                in_accept;
  logic                out_free;
  logic [IDX_W-1:0]    rom_idx;
  sample_t             rom_data;
  logic signed [16:0]  rom_diff;
  logic signed [16:0]  interp;
  logic [IDX_W-1:0]    mod_i0, car_i0;
  logic [FRAC_W-1:0]   mod_frac, car_frac;
  logic                mul_load;
  logic signed [31:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [33:0]  r15;
  logic signed [32:0]  r16;
  logic [PHASE_W-1:0]  car_step_eff;

  function automatic sample_t sat16(input logic signed [33:0] v);
    if (v > 34'sd32767)       return 16'sh7fff;
    else if (v < -34'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mod_i0   = mod_phase_q[PHASE_W-1 -: IDX_W];
  assign car_i0   = car_phase_q[PHASE_W-1 -: IDX_W];
  assign mod_frac = mod_phase_q[PHASE_W-IDX_W-1 -: FRAC_W];
  assign car_frac = car_phase_q[PHASE_W-IDX_W-1 -: FRAC_W];

  // single table read port, shared by both oscillators
  always_comb begin
    case (state_q)
      ST_MA:   rom_idx = mod_i0;
      ST_MB:   rom_idx = mod_i0 + 10'd1;
      ST_CA:   rom_idx = car_i0;
      ST_CB:   rom_idx = car_i0 + 10'd1;
      default: rom_idx = mod_i0;
    endcase
  end

  assign rom_data = sine_lookup(rom_idx);

  always_comb begin
    mul_load = 1'b1;
    case (state_q)
      ST_CA: begin
        mul_a = {16'b0, mod_frac};
        mul_b = d_q;
      end
      ST_DV: begin
        mul_a = {1'b0, dev_step_q};
        mul_b = {m_q[15], m_q};
      end
      ST_CW: begin
        mul_a = {16'b0, car_frac};
        mul_b = d_q;
      end
      ST_ML: begin
        mul_a = {{16{left_q[15]}}, left_q};
        mul_b = {w_q[15], w_q};
      end
      ST_MR: begin
        mul_a = {{16{right_q[15]}}, right_q};
        mul_b = {w_q[15], w_q};
      end
      default: begin
        mul_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
      end
    endcase
  end

  wtfm_mul u_mul (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .r15_o  (r15),
    .r16_o  (r16)
  );

  assign car_step_eff = {1'b0, carrier_step_q} + r15[PHASE_W-1:0];

  always_comb begin
    case (state_q)
      ST_MB: rom_diff = {rom_data[15], rom_data} - {ms0_q[15], ms0_q};
      default: rom_diff = {rom_data[15], rom_data} - {cs0_q[15], cs0_q};
    endcase
  end

  always_comb begin
    case (state_q)
      ST_CB:   interp = {ms0_q[15], ms0_q} + r16[16:0];
      default: interp = {cs0_q[15], cs0_q} + r16[16:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = enable_q ? ST_MA : ST_FIN;
      ST_MA:   state_d = ST_MB;
      ST_MB:   state_d = ST_CA;
      ST_CA:   state_d = ST_CB;
      ST_CB:   state_d = ST_DV;
      ST_DV:   state_d = ST_CW;
      ST_CW:   state_d = ST_WW;
      ST_WW:   state_d = ST_ML;
      ST_ML:   state_d = ST_MR;
      ST_MR:   state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      carrier_step_q <= CARRIER_STEP_RST;
      mod_step_q     <= MOD_STEP_RST;
      dev_step_q     <= '0;
      chan_count_q   <= CHAN_COUNT_RST;
      enable_q       <= 1'b0;
      mod_phase_q    <= '0;
      car_phase_q    <= '0;
      silent_q       <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CARRIER_STEP: carrier_step_q <= cfg_data_i;
          REG_MOD_STEP:     mod_step_q     <= cfg_data_i;
          REG_DEV_STEP:     dev_step_q     <= cfg_data_i;
          REG_CHAN_COUNT:   chan_count_q   <= cfg_data_i[1:0];
          REG_ENABLE:       enable_q       <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_accept) silent_q <= !enable_q;
      // both oscillators were sampled at the old phases by now
      if (state_q == ST_CW) begin
        mod_phase_q <= mod_phase_q + {1'b0, mod_step_q};
        car_phase_q <= car_phase_q + car_step_eff;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      left_q  <= sample_left_i;
      right_q <= sample_right_i;
    end
    case (state_q)
      ST_MA: ms0_q <= rom_data;
      ST_MB: d_q   <= rom_diff;
      ST_CA: cs0_q <= rom_data;
      ST_CB: begin
        d_q <= rom_diff;
        m_q <= interp[15:0];
      end
      ST_WW: w_q  <= interp[15:0];
      ST_MR: ol_q <= sat16(r15);
      ST_FIN: begin
        if (out_free) begin
          out_left_q  <= (!silent_q && chan_count_q != 2'd0) ? ol_q : '0;
          out_right_q <= (!silent_q && chan_count_q[1]) ? sat16(r15) : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

endmodule

[hdl/wtfm_checker.sv]
module wtfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [15:0] out_left_i,
  input logic [15:0] out_right_i
);

  // one frame at a time: busy right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input taken while a frame is in flight");

  // a result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result without a frame in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_i |=> !$rose(out_valid_i))
    else $error("result raised straight from idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_left_i) && $stable(out_right_i))
    else $error("stalled result changed");

endmodule

bind warble_tone_fm_modulator wtfm_checker u_wtfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_left_i  (out_left_o),
  .out_right_i (out_right_o)
);
